@@ hdl/mvag_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mvag_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS = 16;
  localparam int VISC_FRAC = 16;
  localparam int COORD_W   = 32;
  localparam int VISC_W    = 24;
  localparam int ACC_W     = 48;
  localparam int CNT_W     = 8;

  // Shared multiplier and derived datapath widths.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int U_W    = FRAC_BITS + 2;
  localparam int TERM_W = MUL_W + U_W + 1;

  // Sequencer step counts (last step index of each phase).
  localparam int IDX_W      = 5;
  localparam int CROSS_LAST = 6;
  localparam int SQ_LAST    = 3;
  localparam int SQRT_LAST  = 31;
  localparam int DIV_LAST   = FRAC_BITS;
  localparam int TERM_LAST  = 7;
  localparam int OUT_LAST   = 3;

  localparam logic [VISC_W-1:0] VISC_RESET = VISC_W'(65536);

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CROSS, OP_MAG, OP_NORM,
    OP_SQ, OP_SQRT, OP_DIV, OP_TERM, OP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic zero_area;
    logic norm_done;
    logic last;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/mvag_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mvag_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  mvag_pkg::status_t status,
  output mvag_pkg::cmd_t    cmd
);
  import mvag_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CROSS = 10'b00_0000_0010,
    S_MAG   = 10'b00_0000_0100,
    S_NORM  = 10'b00_0000_1000,
    S_SQ    = 10'b00_0001_0000,
    S_SQRT  = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_TERM  = 10'b00_1000_0000,
    S_WAIT  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_valid_next;

  // Step through a phase; at its last step move on.
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    out_valid_next = out_valid;
    cmd.op         = OP_NONE;
    cmd.idx        = idx;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CROSS;
          idx_next   = '0;
        end
      end
      S_CROSS: begin
        cmd.op = OP_CROSS;
        if (idx == IDX_W'(CROSS_LAST)) begin
          idx_next   = '0;
          state_next = S_MAG;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_MAG: begin
        cmd.op = OP_MAG;
        if (!status.zero_area) begin
          state_next = S_NORM;
        end else if (status.last) begin
          state_next = S_WAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (status.norm_done) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (idx == IDX_W'(SQ_LAST)) begin
          idx_next   = '0;
          state_next = S_SQRT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (idx == IDX_W'(SQRT_LAST)) begin
          idx_next   = '0;
          state_next = S_DIV;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (idx == IDX_W'(DIV_LAST)) begin
          idx_next   = '0;
          state_next = S_TERM;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_TERM: begin
        cmd.op = OP_TERM;
        if (idx == IDX_W'(TERM_LAST)) begin
          idx_next   = '0;
          state_next = status.last ? S_WAIT : S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_WAIT: begin
        // The result register must be empty before it is rewritten.
        if (!out_valid || out_ready) begin
          idx_next   = '0;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        if (idx == IDX_W'(OUT_LAST)) begin
          idx_next       = '0;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register is not one-hot");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !out_valid)
    else $error("result register rewritten while still full");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output phase");
`endif

endmodule
`default_nettype wire

@@ hdl/mvag_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mvag_dp (
  input  wire                                   clk,
  input  wire                                   rst,
  input  mvag_pkg::cmd_t                        cmd,
  output mvag_pkg::status_t                     status,
  input  wire                                   cfg_write,
  input  wire        [mvag_pkg::VISC_W-1:0]     cfg_data,
  input  wire signed [mvag_pkg::COORD_W-1:0]    center_x,
  input  wire signed [mvag_pkg::COORD_W-1:0]    center_y,
  input  wire signed [mvag_pkg::COORD_W-1:0]    center_z,
  input  wire signed [mvag_pkg::COORD_W-1:0]    corner_a_x,
  input  wire signed [mvag_pkg::COORD_W-1:0]    corner_a_y,
  input  wire signed [mvag_pkg::COORD_W-1:0]    corner_a_z,
  input  wire signed [mvag_pkg::COORD_W-1:0]    corner_b_x,
  input  wire signed [mvag_pkg::COORD_W-1:0]    corner_b_y,
  input  wire signed [mvag_pkg::COORD_W-1:0]    corner_b_z,
  input  wire                                   fixed_vertex,
  input  wire                                   last_triangle,
  output logic signed [mvag_pkg::COORD_W-1:0]   new_x,
  output logic signed [mvag_pkg::COORD_W-1:0]   new_y,
  output logic signed [mvag_pkg::COORD_W-1:0]   new_z,
  output logic signed [mvag_pkg::COORD_W-1:0]   grad_x,
  output logic signed [mvag_pkg::COORD_W-1:0]   grad_y,
  output logic signed [mvag_pkg::COORD_W-1:0]   grad_z,
  output logic        [mvag_pkg::CNT_W-1:0]     skipped_count
);
  import mvag_pkg::*;

  // Operand lanes of the cross-product pattern a[j] * b[k] - a[k] * b[j].
  localparam logic [1:0] SEL_A [8] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0};
  localparam logic [1:0] SEL_B [8] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1:COORD_W-1] == {(PROD_W-COORD_W+1){v[PROD_W-1]}}) begin
      return v[COORD_W-1:0];
    end
    return v[PROD_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [63:0] v);
    if (v[63:ACC_W-1] == {(64-ACC_W+1){v[63]}}) begin
      return v[ACC_W-1:0];
    end
    return v[63] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

  // Item registers.
  logic signed [COORD_W-1:0] c  [3];
  logic signed [COORD_W-1:0] p1 [3];
  logic signed [COORD_W-1:0] p2 [3];
  logic signed [MUL_W-1:0]   e  [3];
  logic                      fixed_r, last_r;
  logic [VISC_W-1:0]         visc;

  // Working registers.
  logic signed [63:0]        n   [3];
  logic [63:0]               m   [3];
  logic [63:0]               sx, sr, sbit;
  logic [COORD_W-1:0]        rem [3];
  logic [QUO_W-1:0]          q   [3];
  logic signed [TERM_W-1:0]  t;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   sum [3];
  logic [CNT_W-1:0]          degen;

  // Input staging.
  logic signed [COORD_W-1:0] in_c [3];
  logic signed [COORD_W-1:0] in_a [3];
  logic signed [COORD_W-1:0] in_b [3];
  logic signed [COORD_W-1:0] p1_in [3];
  logic signed [COORD_W-1:0] p2_in [3];

  always_comb begin
    in_c[0] = center_x;   in_c[1] = center_y;   in_c[2] = center_z;
    in_a[0] = corner_a_x; in_a[1] = corner_a_y; in_a[2] = corner_a_z;
    in_b[0] = corner_b_x; in_b[1] = corner_b_y; in_b[2] = corner_b_z;
    for (int i = 0; i < 3; i++) begin
      p1_in[i] = sat32(PROD_W'(in_a[i]) - PROD_W'(in_c[i]));
      p2_in[i] = sat32(PROD_W'(in_b[i]) - PROD_W'(in_c[i]));
    end
  end

  // Derived values: unit normal, saturated gradient, divisor, shift tests.
  logic signed [U_W-1:0]     u [3];
  logic signed [COORD_W-1:0] g [3];
  logic [COORD_W-1:0]        norm_d;
  logic                      big, done;
  logic [U_W-1:0]            uq;

  always_comb begin
    big  = 1'b0;
    done = 1'b1;
    uq   = '0;
    for (int i = 0; i < 3; i++) begin
      uq   = {1'b0, q[i]};
      u[i] = n[i][63] ? $signed(~uq + 1'b1) : $signed(uq);
      g[i] = sat32(PROD_W'(sum[i]));
      big  = big | (|m[i][63:38]);
      done = done & ~(|m[i][63:30]);
    end
    norm_d = (sr[COORD_W-1:0] == '0) ? COORD_W'(1) : sr[COORD_W-1:0];
  end

  assign status.zero_area = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  assign status.norm_done = done;
  assign status.last      = last_r;

  // Shared multiplier operand selection.
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic [2:0]              ps;
  logic [1:0]              ls;

  always_comb begin
    ps    = cmd.idx[2:0];
    ls    = (cmd.idx < IDX_W'(3)) ? cmd.idx[1:0] : 2'd0;
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_CROSS: begin
        mul_a = MUL_W'(p1[SEL_A[ps]]);
        mul_b = MUL_W'(p2[SEL_B[ps]]);
      end
      OP_TERM: begin
        mul_a = e[SEL_A[ps]];
        mul_b = MUL_W'(u[SEL_B[ps]]);
      end
      OP_SQ: begin
        mul_a = $signed({(MUL_W-30)'(0), m[ls][29:0]});
        mul_b = $signed({(MUL_W-30)'(0), m[ls][29:0]});
      end
      OP_OUT: begin
        mul_a = MUL_W'(g[ls]);
        mul_b = $signed({(MUL_W-VISC_W)'(0), visc});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Per-step consume index and helper values.
  logic [IDX_W-1:0]         k;
  logic [1:0]               kc;
  logic [1:0]               ac;
  logic signed [TERM_W-1:0] tsh;
  logic [COORD_W-1:0]       rcur [3];
  logic [COORD_W:0]         trial [3];
  logic signed [PROD_W-1:0] stepv [3];

  always_comb begin
    k   = cmd.idx - 1'b1;
    kc  = k[2:1];
    ac  = cmd.idx[2:1] - 2'd1;
    tsh = t >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      rcur[i]  = (cmd.idx == '0) ? {{(COORD_W-29){1'b0}}, m[i][29:1]} : rem[i];
      trial[i] = {rcur[i], (cmd.idx == '0) ? m[i][0] : 1'b0};
      stepv[i] = PROD_W'(c[i]) - (prod >>> VISC_FRAC);
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      visc <= VISC_RESET;
    end else if (cfg_write) begin
      visc <= cfg_data;
    end
  end

  // Gradient sums and zero-area count.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
      end
      degen <= '0;
    end else begin
      if (cmd.op == OP_MAG && status.zero_area && degen != '1) begin
        degen <= degen + 1'b1;
      end
      if (cmd.op == OP_TERM && cmd.idx[0] && cmd.idx >= IDX_W'(3)) begin
        sum[ac] <= sat48(64'(sum[ac]) + 64'(tsh));
      end
      if (cmd.op == OP_OUT && cmd.idx == IDX_W'(OUT_LAST)) begin
        for (int i = 0; i < 3; i++) begin
          sum[i] <= '0;
        end
        degen <= '0;
      end
    end
  end

  // Per-triangle working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          c[i]  <= in_c[i];
          p1[i] <= p1_in[i];
          p2[i] <= p2_in[i];
          e[i]  <= MUL_W'(p1_in[i]) - MUL_W'(p2_in[i]);
        end
        fixed_r <= fixed_vertex;
        last_r  <= last_triangle;
      end
      OP_CROSS: begin
        if (cmd.idx != '0) begin
          if (!k[0]) begin
            n[kc] <= prod[63:0];
          end else begin
            n[kc] <= n[kc] - prod[63:0];
          end
        end
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          m[i] <= n[i][63] ? 64'(0) - n[i] : n[i];
        end
      end
      OP_NORM: begin
        if (!done) begin
          for (int i = 0; i < 3; i++) begin
            m[i] <= big ? (m[i] >> 8) : (m[i] >> 1);
          end
        end
      end
      OP_SQ: begin
        if (cmd.idx == '0) begin
          sx   <= '0;
          sr   <= '0;
          sbit <= 64'(1) << 62;
        end else begin
          sx <= sx + prod[63:0];
        end
      end
      OP_SQRT: begin
        // One result bit per step.
        if (sx >= sr + sbit) begin
          sx <= sx - (sr + sbit);
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_DIV: begin
        // Three restoring dividers, one quotient bit each per step.
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= {1'b0, norm_d}) begin
            rem[i] <= COORD_W'(trial[i] - {1'b0, norm_d});
            q[i]   <= {((cmd.idx == '0) ? {(QUO_W-1){1'b0}} : q[i][QUO_W-2:0]), 1'b1};
          end else begin
            rem[i] <= trial[i][COORD_W-1:0];
            q[i]   <= {((cmd.idx == '0) ? {(QUO_W-1){1'b0}} : q[i][QUO_W-2:0]), 1'b0};
          end
        end
      end
      OP_TERM: begin
        if (cmd.idx != '0 && cmd.idx <= IDX_W'(6)) begin
          if (!k[0]) begin
            t <= prod[TERM_W-1:0];
          end else begin
            t <= t - $signed(prod[TERM_W-1:0]);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result registers.
  logic signed [COORD_W-1:0] new_r  [3];
  logic signed [COORD_W-1:0] grad_r [3];

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT && cmd.idx != '0) begin
      new_r[k[1:0]]  <= fixed_r ? c[k[1:0]] : sat32(stepv[k[1:0]]);
      grad_r[k[1:0]] <= g[k[1:0]];
      if (cmd.idx == IDX_W'(OUT_LAST)) begin
        skipped_count <= degen;
      end
    end
  end

  assign new_x  = new_r[0];
  assign new_y  = new_r[1];
  assign new_z  = new_r[2];
  assign grad_x = grad_r[0];
  assign grad_y = grad_r[1];
  assign grad_z = grad_r[2];

endmodule
`default_nettype wire

@@ hdl/mesh_vertex_area_gradient_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake              Payload
// input     in_valid / in_ready    center_*, corner_a_*, corner_b_*, fixed_vertex,
//                                  last_triangle
// output    out_valid / out_ready  new_*, grad_*, skipped_count
// config    cfg_write              cfg_data (viscosity)
//
// A triangle is loaded, then passes through the cross product, the magnitudes, the
// normalizing shift, the squared norm, the bit-serial square root, the three quotient
// lanes and the gradient term, with all products formed on one shared multiplier. A
// zero-area triangle ends after the magnitudes. The last triangle of a vertex then
// passes through an output phase to form the result. Reset is synchronous
// and clears the sums, the count and the controller. A new item is taken while a result
// waits; only the next result waits for the output register to empty.
module mesh_vertex_area_gradient_step (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire        [mvag_pkg::VISC_W-1:0]   cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire signed [mvag_pkg::COORD_W-1:0]  center_x,
  input  wire signed [mvag_pkg::COORD_W-1:0]  center_y,
  input  wire signed [mvag_pkg::COORD_W-1:0]  center_z,
  input  wire signed [mvag_pkg::COORD_W-1:0]  corner_a_x,
  input  wire signed [mvag_pkg::COORD_W-1:0]  corner_a_y,
  input  wire signed [mvag_pkg::COORD_W-1:0]  corner_a_z,
  input  wire signed [mvag_pkg::COORD_W-1:0]  corner_b_x,
  input  wire signed [mvag_pkg::COORD_W-1:0]  corner_b_y,
  input  wire signed [mvag_pkg::COORD_W-1:0]  corner_b_z,
  input  wire                                 fixed_vertex,
  input  wire                                 last_triangle,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [mvag_pkg::COORD_W-1:0] new_x,
  output logic signed [mvag_pkg::COORD_W-1:0] new_y,
  output logic signed [mvag_pkg::COORD_W-1:0] new_z,
  output logic signed [mvag_pkg::COORD_W-1:0] grad_x,
  output logic signed [mvag_pkg::COORD_W-1:0] grad_y,
  output logic signed [mvag_pkg::COORD_W-1:0] grad_z,
  output logic        [mvag_pkg::CNT_W-1:0]   skipped_count
);
  import mvag_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  mvag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  mvag_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .corner_a_x    (corner_a_x),
    .corner_a_y    (corner_a_y),
    .corner_a_z    (corner_a_z),
    .corner_b_x    (corner_b_x),
    .corner_b_y    (corner_b_y),
    .corner_b_z    (corner_b_z),
    .fixed_vertex  (fixed_vertex),
    .last_triangle (last_triangle),
    .new_x         (new_x),
    .new_y         (new_y),
    .new_z         (new_z),
    .grad_x        (grad_x),
    .grad_y        (grad_y),
    .grad_z        (grad_z),
    .skipped_count (skipped_count)
  );

endmodule
`default_nettype wire
